// ----- rtl/pspc_pkg.sv -----
// shared types, constants and the digestinfo byte table for the pkcs#1 v1.5 pad checker
// no dependencies
`timescale 1ns / 1ps

package pspc_pkg;

  localparam int MAX_BLOCK_BYTES = 512;
  localparam int MAX_HASH_BYTES  = 64;
  localparam int HASH_AW         = $clog2(MAX_HASH_BYTES);
  localparam int FIDX_W          = HASH_AW + 1;
  localparam int BLEN_W          = 10;
  localparam int DLEN_W          = 7;
  localparam int POS_W           = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int CFG_W           = 10;
  localparam int DINFO_LEN       = 19;
  localparam int SHA256_LEN      = 32;

  localparam logic [0:0] CFG_BLOCK_LENGTH  = 1'd0;
  localparam logic [0:0] CFG_DIGEST_LENGTH = 1'd1;

  localparam logic REQ_HASH  = 1'b0;
  localparam logic REQ_BLOCK = 1'b1;

  localparam logic [2:0] PH_HDR0  = 3'd0;
  localparam logic [2:0] PH_HDR1  = 3'd1;
  localparam logic [2:0] PH_PAD   = 3'd2;
  localparam logic [2:0] PH_DINFO = 3'd3;
  localparam logic [2:0] PH_HASH  = 3'd4;
  localparam logic [2:0] PH_TAIL  = 3'd5;

  localparam logic [2:0] V_OK        = 3'd0;
  localparam logic [2:0] V_BAD_HDR   = 3'd1;
  localparam logic [2:0] V_NO_SEP    = 3'd2;
  localparam logic [2:0] V_BAD_DINFO = 3'd3;
  localparam logic [2:0] V_BAD_HASH  = 3'd4;
  localparam logic [2:0] V_BAD_LEN   = 3'd5;

  typedef struct packed {
    logic       valid;
    logic [2:0] verdict;
  } result_t;

  function automatic logic [7:0] dinfo_byte(input logic [4:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:  b = 8'h30;
      5'd1:  b = 8'h31;
      5'd2:  b = 8'h30;
      5'd3:  b = 8'h0d;
      5'd4:  b = 8'h06;
      5'd5:  b = 8'h09;
      5'd6:  b = 8'h60;
      5'd7:  b = 8'h86;
      5'd8:  b = 8'h48;
      5'd9:  b = 8'h01;
      5'd10: b = 8'h65;
      5'd11: b = 8'h03;
      5'd12: b = 8'h04;
      5'd13: b = 8'h02;
      5'd14: b = 8'h01;
      5'd15: b = 8'h05;
      5'd16: b = 8'h00;
      5'd17: b = 8'h04;
      5'd18: b = 8'h20;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/pspc_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module pspc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/pspc_parse.sv -----
// block byte parser: phase, position, field index and fail code, verdict on last byte
// depends on pspc_pkg
`timescale 1ns / 1ps

module pspc_parse (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          blk_valid,
  input  logic [7:0]                    blk_byte,
  input  logic                          blk_last,
  input  logic [pspc_pkg::BLEN_W-1:0]   block_length,
  input  logic [pspc_pkg::DLEN_W-1:0]   digest_length,
  input  logic [7:0]                    hash_data,
  output logic [pspc_pkg::HASH_AW-1:0]  hash_rd_addr,
  output pspc_pkg::result_t             result
);

  logic [2:0]                    phase_r, phase_nxt;
  logic [pspc_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [pspc_pkg::FIDX_W-1:0]   fidx_r, fidx_nxt;
  logic [2:0]                    fail_r, fail_nxt;
  logic [pspc_pkg::DLEN_W-1:0]   dl_eff;
  logic                          sha;
  logic [pspc_pkg::FIDX_W-1:0]   fidx_inc;
  logic [pspc_pkg::BLEN_W:0]     count;
  logic                          len_bad;
  logic [2:0]                    verdict;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    fidx_nxt  = fidx_r;
    fail_nxt  = fail_r;
    verdict   = pspc_pkg::V_OK;
    dl_eff    = (digest_length > pspc_pkg::DLEN_W'(pspc_pkg::MAX_HASH_BYTES)) ?
                pspc_pkg::DLEN_W'(pspc_pkg::MAX_HASH_BYTES) : digest_length;
    sha       = (digest_length == pspc_pkg::DLEN_W'(pspc_pkg::SHA256_LEN));
    fidx_inc  = fidx_r + pspc_pkg::FIDX_W'(1);
    count     = {1'b0, pos_r} + (pspc_pkg::BLEN_W + 1)'(1);
    len_bad   = (block_length > pspc_pkg::BLEN_W'(pspc_pkg::MAX_BLOCK_BYTES)) ||
                (count != {1'b0, block_length});
    if (blk_valid) begin
      if (fail_r == pspc_pkg::V_OK) begin
        case (phase_r)
          pspc_pkg::PH_HDR0: begin
            if (blk_byte != 8'h00) fail_nxt = pspc_pkg::V_BAD_HDR;
            else phase_nxt = pspc_pkg::PH_HDR1;
          end
          pspc_pkg::PH_HDR1: begin
            if (blk_byte != 8'h01) fail_nxt = pspc_pkg::V_BAD_HDR;
            else phase_nxt = pspc_pkg::PH_PAD;
          end
          pspc_pkg::PH_PAD: begin
            if (blk_byte == 8'hff) begin
              phase_nxt = phase_r;
            end else if (blk_byte != 8'h00) begin
              fail_nxt = pspc_pkg::V_NO_SEP;
            end else begin
              fidx_nxt = '0;
              if (sha) begin
                // need digestinfo plus a full sha-256 hash after the separator
                if ({1'b0, block_length} <
                    ({1'b0, pos_r} +
                     (pspc_pkg::BLEN_W + 1)'(pspc_pkg::DINFO_LEN + pspc_pkg::SHA256_LEN + 1)))
                  fail_nxt = pspc_pkg::V_BAD_DINFO;
                else
                  phase_nxt = pspc_pkg::PH_DINFO;
              end else begin
                phase_nxt = (dl_eff != '0) ? pspc_pkg::PH_HASH : pspc_pkg::PH_TAIL;
              end
            end
          end
          pspc_pkg::PH_DINFO: begin
            if (fidx_r >= pspc_pkg::FIDX_W'(pspc_pkg::DINFO_LEN) ||
                blk_byte != pspc_pkg::dinfo_byte(fidx_r[4:0])) begin
              fail_nxt = pspc_pkg::V_BAD_DINFO;
            end else if (fidx_inc == pspc_pkg::FIDX_W'(pspc_pkg::DINFO_LEN)) begin
              fidx_nxt  = '0;
              phase_nxt = (dl_eff != '0) ? pspc_pkg::PH_HASH : pspc_pkg::PH_TAIL;
            end else begin
              fidx_nxt = fidx_inc;
            end
          end
          pspc_pkg::PH_HASH: begin
            if (fidx_r[pspc_pkg::FIDX_W-1] || blk_byte != hash_data) begin
              fail_nxt = pspc_pkg::V_BAD_HASH;
            end else begin
              fidx_nxt = fidx_inc;
              if (pspc_pkg::DLEN_W'(fidx_inc) >= dl_eff) phase_nxt = pspc_pkg::PH_TAIL;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
      if (blk_last) begin
        if (len_bad) begin
          verdict = pspc_pkg::V_BAD_LEN;
        end else if (fail_nxt != pspc_pkg::V_OK) begin
          verdict = fail_nxt;
        end else begin
          case (phase_nxt)
            pspc_pkg::PH_HDR0,
            pspc_pkg::PH_HDR1:  verdict = pspc_pkg::V_BAD_HDR;
            pspc_pkg::PH_PAD:   verdict = pspc_pkg::V_NO_SEP;
            pspc_pkg::PH_DINFO: verdict = pspc_pkg::V_BAD_DINFO;
            pspc_pkg::PH_HASH:  verdict = sha ? pspc_pkg::V_BAD_DINFO : pspc_pkg::V_BAD_HASH;
            default:            verdict = pspc_pkg::V_OK;
          endcase
        end
        phase_nxt = pspc_pkg::PH_HDR0;
        pos_nxt   = '0;
        fidx_nxt  = '0;
        fail_nxt  = pspc_pkg::V_OK;
      end else if (pos_r < pspc_pkg::POS_W'(pspc_pkg::MAX_BLOCK_BYTES)) begin
        pos_nxt = pos_r + pspc_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pspc_pkg::PH_HDR0;
      pos_r   <= '0;
      fidx_r  <= '0;
      fail_r  <= pspc_pkg::V_OK;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      fidx_r  <= fidx_nxt;
      fail_r  <= fail_nxt;
    end
  end

  // prefetch the hash entry the next block byte will compare against
  assign hash_rd_addr   = fidx_nxt[pspc_pkg::HASH_AW-1:0];
  assign result.valid   = blk_valid && blk_last;
  assign result.verdict = verdict;

endmodule

// ----- rtl/pspc_outbuf.sv -----
// two-entry verdict output buffer: output register plus skid register
// depends on pspc_pkg
`timescale 1ns / 1ps

module pspc_outbuf (
  input  logic              clk,
  input  logic              rst_n,
  input  pspc_pkg::result_t res_in,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_verdict
);

  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_verdict_r, out_verdict_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  logic [2:0] skid_verdict_r, skid_verdict_nxt;
  logic       out_free;

  always_comb begin
    out_free         = !out_valid_r || !out_stall;
    out_valid_nxt    = out_valid_r;
    out_verdict_nxt  = out_verdict_r;
    skid_valid_nxt   = skid_valid_r;
    skid_verdict_nxt = skid_verdict_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt   = 1'b1;
        out_verdict_nxt = skid_verdict_r;
        skid_valid_nxt  = 1'b0;
      end else begin
        out_valid_nxt   = res_in.valid;
        out_verdict_nxt = res_in.verdict;
      end
    end else if (res_in.valid) begin
      skid_valid_nxt   = 1'b1;
      skid_verdict_nxt = res_in.verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_verdict_r  <= out_verdict_nxt;
    skid_verdict_r <= skid_verdict_nxt;
  end

  assign full        = skid_valid_r;
  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

endmodule

// ----- rtl/pkcs1_signature_pad_checker.sv -----
// pkcs#1 v1.5 signature padding checker, top level
// depends on pspc_pkg, pspc_ram, pspc_parse, pspc_outbuf
//
// usage: the input channel (in_valid/in_stall) carries one byte per transfer.
// in_req_type 0 loads the next expected hash byte into a 64-entry ram (loads
// past 64 are dropped); in_req_type 1 is a decrypted block byte, most
// significant first, with in_last_byte on the final one. the block is checked
// against 00 01, ff run, 00, sha-256 digestinfo (when digest_length is 32) and
// the loaded hash. the last block byte yields one verdict on the output channel
// (out_valid/out_stall) via the output buffer; after it the parser and
// hash fill count start over. one byte is taken every cycle while in_stall is
// low; the ram read for the next hash compare is issued while the current byte
// is parsed, and a load to that same entry is forwarded. a stalled receiver is
// covered by a two-deep output buffer, so in_stall rises only when both entries
// hold a verdict. reset (rst_n low, synchronous) restores block_length 256 and
// digest_length 32 and clears the parser; ram contents stay undefined.
// configuration writes (cfg_we, cfg_index, cfg_wdata) take effect next cycle.
`timescale 1ns / 1ps

module pkcs1_signature_pad_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_req_type,
  input  logic [7:0]                 in_byte_value,
  input  logic                       in_last_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 out_verdict,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [pspc_pkg::CFG_W-1:0] cfg_wdata
);

  logic [pspc_pkg::BLEN_W-1:0]   block_length_r, block_length_nxt;
  logic [pspc_pkg::DLEN_W-1:0]   digest_length_r, digest_length_nxt;
  logic [pspc_pkg::FIDX_W-1:0]   fill_r, fill_nxt;
  logic                          in_xfer;
  logic                          load_en;
  logic                          blk_valid;
  logic [pspc_pkg::HASH_AW-1:0]  rd_addr;
  logic [7:0]                    ram_q;
  logic [7:0]                    hash_data;
  logic                          byp_hit_r;
  logic [7:0]                    byp_data_r;
  logic                          buf_full;
  pspc_pkg::result_t             result;

  assign in_xfer   = in_valid && !in_stall;
  assign load_en   = in_xfer && (in_req_type == pspc_pkg::REQ_HASH) &&
                     (fill_r < pspc_pkg::FIDX_W'(pspc_pkg::MAX_HASH_BYTES));
  assign blk_valid = in_xfer && (in_req_type == pspc_pkg::REQ_BLOCK);
  assign in_stall  = buf_full;

  always_comb begin
    block_length_nxt  = block_length_r;
    digest_length_nxt = digest_length_r;
    if (cfg_we) begin
      case (cfg_index)
        pspc_pkg::CFG_BLOCK_LENGTH:  block_length_nxt  = cfg_wdata[pspc_pkg::BLEN_W-1:0];
        pspc_pkg::CFG_DIGEST_LENGTH: digest_length_nxt = cfg_wdata[pspc_pkg::DLEN_W-1:0];
        default: block_length_nxt = block_length_r;
      endcase
    end
    fill_nxt = fill_r;
    if (result.valid) fill_nxt = '0;
    else if (load_en) fill_nxt = fill_r + pspc_pkg::FIDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_length_r  <= pspc_pkg::BLEN_W'(256);
      digest_length_r <= pspc_pkg::DLEN_W'(pspc_pkg::SHA256_LEN);
      fill_r          <= '0;
      byp_hit_r       <= 1'b0;
    end else begin
      block_length_r  <= block_length_nxt;
      digest_length_r <= digest_length_nxt;
      fill_r          <= fill_nxt;
      byp_hit_r       <= load_en && (fill_r[pspc_pkg::HASH_AW-1:0] == rd_addr);
    end
    byp_data_r <= in_byte_value;
  end

  // ram reads old data on a same-entry write, so forward the written byte
  assign hash_data = byp_hit_r ? byp_data_r : ram_q;

  pspc_ram #(
    .WIDTH (8),
    .DEPTH (pspc_pkg::MAX_HASH_BYTES)
  ) u_hash_ram (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_addr (fill_r[pspc_pkg::HASH_AW-1:0]),
    .wr_data (in_byte_value),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  pspc_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .blk_valid     (blk_valid),
    .blk_byte      (in_byte_value),
    .blk_last      (in_last_byte),
    .block_length  (block_length_r),
    .digest_length (digest_length_r),
    .hash_data     (hash_data),
    .hash_rd_addr  (rd_addr),
    .result        (result)
  );

  pspc_outbuf u_outbuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_in      (result),
    .full        (buf_full),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_verdict (out_verdict)
  );

endmodule
